@@ sv/tcw_pkg.sv @@
// Shared constants, types and codes for the text console character writer.
`timescale 1ns / 1ps
package tcw_pkg;

  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int CELLS    = ROWS * COLUMNS;
  localparam int COPY_N   = (ROWS - 1) * COLUMNS;
  localparam int COL_W    = $clog2(COLUMNS);
  localparam int ROW_W    = $clog2(ROWS);
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int CNT_W    = $clog2(CELLS + 1);
  localparam int LOC_W    = 11;
  localparam int TAB_STEP = 8;

  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  localparam logic CFG_DEFAULT_FG = 1'b0;
  localparam logic CFG_DEFAULT_BG = 1'b1;

  typedef enum logic [1:0] {
    CMD_WRITE_DEFAULT = 2'd0,
    CMD_WRITE_COLOR   = 2'd1,
    CMD_CLEAR         = 2'd2,
    CMD_READ          = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic sweep;
  } ctl_t;

  typedef struct packed {
    logic need_sweep;
    logic sweep_last;
  } stat_t;

endpackage

@@ sv/tcw_ctrl.sv @@
// Sequencer for command accept, screen sweep (scroll or clear) and result beat.
`timescale 1ns / 1ps
module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output ctl_t  ctl,
  output logic  busy,
  output logic  done
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = stat.need_sweep ? ST_SWEEP : ST_DONE;
        end
      end
      ST_SWEEP: begin
        if (stat.sweep_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // No beat is taken while reset is held.
  always_comb begin
    ctl.accept = 1'b0;
    ctl.sweep  = 1'b0;
    busy       = 1'b1;
    done       = 1'b0;
    case (state)
      ST_IDLE: begin
        ctl.accept = start && !rst;
        busy       = rst;
      end
      ST_SWEEP: begin
        ctl.sweep = 1'b1;
      end
      ST_DONE: begin
        done = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

@@ sv/tcw_datapath.sv @@
// Cursor logic, default colour registers, screen memory and sweep counter.
`timescale 1ns / 1ps
module tcw_datapath
  import tcw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  ctl_t              ctl,
  output stat_t             stat,
  input  logic [1:0]        command,
  input  logic [7:0]        char_code,
  input  logic [3:0]        char_fg,
  input  logic [3:0]        char_bg,
  input  logic [10:0]       read_address,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [3:0]        cfg_data,
  output logic [LOC_W-1:0]  cursor_location,
  output logic              scrolled,
  output logic [15:0]       read_data
);

  logic [15:0] mem [CELLS];
  logic [15:0] mem_q;

  logic [3:0]       default_fg;
  logic [3:0]       default_bg;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [CNT_W-1:0] sweep_cnt;
  logic             sweep_copy;
  logic             read_ok;

  cmd_t             cmd;
  logic             is_write;
  logic             printable;
  logic [COL_W:0]   col_w;
  logic [ROW_W:0]   row_w;
  logic             overflow;
  logic [ADDR_W-1:0] cur_addr;
  logic [15:0]      blank;
  logic [15:0]      char_cell;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [15:0]       mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CNT_W-1:0]  sweep_prev;
  logic [CNT_W-1:0]  sweep_src;

  assign cmd       = cmd_t'(command);
  assign is_write  = (cmd == CMD_WRITE_DEFAULT) || (cmd == CMD_WRITE_COLOR);
  assign printable = !char_code[7] && (char_code[6:5] != 2'b00);
  assign cur_addr  = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  assign blank     = {default_bg, default_fg, CH_SPACE};
  assign char_cell = (cmd == CMD_WRITE_COLOR) ? {char_bg, char_fg, char_code}
                                              : {default_bg, default_fg, char_code};

  // Cursor movement for a write command.
  always_comb begin
    col_w = {1'b0, col};
    row_w = {1'b0, row};
    case (char_code)
      CH_BACKSPACE: begin
        if (col != '0) begin
          col_w = col_w - (COL_W + 1)'(1);
        end
      end
      CH_TAB: begin
        col_w = (col_w + (COL_W + 1)'(TAB_STEP)) & ~(COL_W + 1)'(TAB_STEP - 1);
      end
      CH_RETURN: begin
        col_w = '0;
      end
      CH_NEWLINE: begin
        col_w = '0;
        row_w = row_w + (ROW_W + 1)'(1);
      end
      default: begin
        if (printable) begin
          col_w = col_w + (COL_W + 1)'(1);
        end
      end
    endcase
    if (col_w >= (COL_W + 1)'(COLUMNS)) begin
      col_w = '0;
      row_w = row_w + (ROW_W + 1)'(1);
    end
    overflow = row_w >= (ROW_W + 1)'(ROWS);
    if (overflow) begin
      row_w = (ROW_W + 1)'(ROWS - 1);
    end
  end

  assign stat.need_sweep = (cmd == CMD_CLEAR) || (is_write && overflow);
  assign stat.sweep_last = sweep_cnt == CNT_W'(CELLS);

  always_ff @(posedge clk) begin
    if (rst) begin
      default_fg <= 4'hF;
      default_bg <= 4'h0;
    end else if (cfg_write) begin
      if (cfg_index == CFG_DEFAULT_FG) begin
        default_fg <= cfg_data;
      end else begin
        default_bg <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col        <= '0;
      row        <= '0;
      scrolled   <= 1'b0;
      read_ok    <= 1'b0;
      sweep_copy <= 1'b0;
      sweep_cnt  <= '0;
    end else if (ctl.accept) begin
      scrolled   <= is_write && overflow;
      read_ok    <= (cmd == CMD_READ) && (int'(read_address) < CELLS);
      sweep_copy <= cmd != CMD_CLEAR;
      sweep_cnt  <= '0;
      if (is_write) begin
        col <= col_w[COL_W-1:0];
        row <= row_w[ROW_W-1:0];
      end else if (cmd == CMD_CLEAR) begin
        col <= '0;
        row <= '0;
      end
    end else if (ctl.sweep) begin
      sweep_cnt <= sweep_cnt + CNT_W'(1);
    end
  end

  // Sweep: cycle k reads cell k+COLUMNS (when scrolling) and writes cell k-1.
  assign sweep_prev = sweep_cnt - CNT_W'(1);
  assign sweep_src  = sweep_cnt + CNT_W'(COLUMNS);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_addr;
    mem_wdata = char_cell;
    mem_re    = 1'b0;
    mem_raddr = ADDR_W'(read_address);
    if (ctl.accept) begin
      mem_we = is_write && printable;
      mem_re = cmd == CMD_READ;
    end else if (ctl.sweep) begin
      mem_we    = sweep_cnt != '0;
      mem_waddr = sweep_prev[ADDR_W-1:0];
      mem_wdata = (sweep_copy && (sweep_prev < CNT_W'(COPY_N))) ? mem_q : blank;
      mem_re    = sweep_copy && (sweep_cnt < CNT_W'(COPY_N));
      mem_raddr = sweep_src[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
    end
  end

  assign cursor_location = LOC_W'(cur_addr);
  assign read_data       = read_ok ? mem_q : 16'h0000;

endmodule

@@ sv/text_console_char_writer.sv @@
// Top level of the text console character writer.
//
// Commands: pulse start with command, char_code, char_fg, char_bg and
// read_address while busy is low; the beat is taken at that clock edge.
// Command 0 writes char_code in the default colours, 1 in char_fg/char_bg,
// 2 clears the screen to blanks and homes the cursor, 3 reads one cell.
// Each command gives one result beat: done is high for one cycle with
// cursor_location, scrolled and read_data. The receiver cannot stall.
// done comes in the cycle after the accept edge for reads, control
// bytes and writes that do not scroll; busy stays high until done has been given.
// Clear and scroll walk the screen memory through its single write port,
// one cell per cycle, before done is given.
// Defaults: cfg_write with cfg_index 0 (foreground) or 1 (background)
// and cfg_data, taken at once while idle.
// Reset (rst, synchronous): cursor at 0, foreground 15, background 0,
// idle. Screen contents are undefined until written or cleared.
`timescale 1ns / 1ps
module text_console_char_writer
  import tcw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [7:0]  char_code,
  input  logic [3:0]  char_fg,
  input  logic [3:0]  char_bg,
  input  logic [10:0] read_address,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data,
  output logic        done,
  output logic [10:0] cursor_location,
  output logic        scrolled,
  output logic [15:0] read_data
);

  ctl_t  ctl;
  stat_t stat;

  tcw_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy),
    .done  (done)
  );

  tcw_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .stat            (stat),
    .command         (command),
    .char_code       (char_code),
    .char_fg         (char_fg),
    .char_bg         (char_bg),
    .read_address    (read_address),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cursor_location (cursor_location),
    .scrolled        (scrolled),
    .read_data       (read_data)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result beat longer than one cycle");

  a_scroll_home: assert property (@(posedge clk) disable iff (rst)
    done && scrolled |-> cursor_location == LOC_W'((ROWS - 1) * COLUMNS))
    else $error("cursor not at start of last row after scroll");

  a_read_no_scroll: assert property (@(posedge clk) disable iff (rst)
    done && (read_data != 16'h0000) |-> !scrolled)
    else $error("read data with scroll");
`endif

endmodule

@@ sim/tb.sv @@
// Testbench for text_console_char_writer: queued commands against a console predictor.
`timescale 1ns / 1ps
module tb;
  import tcw_pkg::*;

  localparam int WATCHDOG_LIMIT = 10000;
  localparam int END_PAUSE      = 20;
  localparam int PHASE_ITEMS    = 130;
  localparam int PHASES         = 5;
  localparam logic [7:0] CH_HIGH_START = 8'h80;
  localparam logic [10:0] ADDR_TOP     = 11'h7FF;

  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  ch;
    logic [3:0]  fg;
    logic [3:0]  bg;
    logic [10:0] addr;
  } console_cmd_t;

  typedef struct packed {
    logic [10:0] loc;
    logic        scr;
    logic [15:0] rdata;
  } console_result_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic [1:0] command;
  logic [7:0] char_code;
  logic [3:0] char_fg;
  logic [3:0] char_bg;
  logic [10:0] read_address;
  logic cfg_write;
  logic cfg_index;
  logic [3:0] cfg_data;
  logic done;
  logic [10:0] cursor_location;
  logic scrolled;
  logic [15:0] read_data;

  text_console_char_writer dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .char_code(char_code),
    .char_fg(char_fg),
    .char_bg(char_bg),
    .read_address(read_address),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .done(done),
    .cursor_location(cursor_location),
    .scrolled(scrolled),
    .read_data(read_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // console model state
  logic [15:0] screen_model [CELLS];
  int model_col;
  int model_row;
  logic [3:0] model_fg;
  logic [3:0] model_bg;

  console_cmd_t command_backlog[$];
  console_result_t pending_results[$];
  console_cmd_t beat;
  console_result_t want;
  logic beat_taken;
  int gap_left;
  int burst_left;
  int idle_cycles;
  int error_count;

  function automatic console_result_t next_console_result(input console_cmd_t c);
    console_result_t r;
    logic [15:0] blank;
    r.scr = 1'b0;
    r.rdata = 16'h0000;
    blank = {model_bg, model_fg, CH_SPACE};
    case (c.cmd)
      CMD_WRITE_DEFAULT, CMD_WRITE_COLOR: begin
        if (c.ch == CH_BACKSPACE && model_col != 0) begin
          model_col = model_col - 1;
        end else if (c.ch == CH_TAB) begin
          model_col = (model_col + TAB_STEP) & ~(TAB_STEP - 1);
        end else if (c.ch == CH_RETURN) begin
          model_col = 0;
        end else if (c.ch == CH_NEWLINE) begin
          model_col = 0;
          model_row = model_row + 1;
        end else if (c.ch >= CH_SPACE && c.ch < CH_HIGH_START) begin
          if (c.cmd == CMD_WRITE_COLOR)
            screen_model[model_row * COLUMNS + model_col] = {c.bg, c.fg, c.ch};
          else
            screen_model[model_row * COLUMNS + model_col] = {model_bg, model_fg, c.ch};
          model_col = model_col + 1;
        end
        if (model_col >= COLUMNS) begin
          model_col = 0;
          model_row = model_row + 1;
        end
        if (model_row >= ROWS) begin
          for (int i = 0; i < CELLS - COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
          for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_model[i] = blank;
          model_row = ROWS - 1;
          r.scr = 1'b1;
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_model[i] = blank;
        model_col = 0;
        model_row = 0;
      end
      default: begin
        if (c.addr < CELLS) r.rdata = screen_model[c.addr];
      end
    endcase
    r.loc = 11'(model_row * COLUMNS + model_col);
    return r;
  endfunction

  function automatic console_cmd_t random_command(input bit text_heavy);
    console_cmd_t c;
    int pick;
    int nl;
    c.ch = 8'($urandom);
    c.fg = 4'($urandom);
    c.bg = 4'($urandom);
    c.addr = 11'($urandom);
    pick = $urandom_range(0, 999);
    if (pick < 4) begin
      c.cmd = CMD_CLEAR;
    end else if (pick < 200) begin
      c.cmd = CMD_READ;
      if ($urandom_range(0, 9) != 0) c.addr = 11'($urandom_range(0, CELLS - 1));
    end else begin
      c.cmd = pick[0] ? CMD_WRITE_COLOR : CMD_WRITE_DEFAULT;
      nl = text_heavy ? 3 : 30;
      pick = $urandom_range(0, 99);
      if (pick < nl) c.ch = CH_NEWLINE;
      else if (pick < nl + 8) c.ch = CH_TAB;
      else if (pick < nl + 14) c.ch = CH_BACKSPACE;
      else if (pick < nl + 17) c.ch = CH_RETURN;
      else if (pick < nl + 20) c.ch = 8'($urandom_range(0, 31));
      else if (pick < nl + 28) c.ch = 8'($urandom_range(128, 255));
      else c.ch = 8'($urandom_range(32, 127));
    end
    return c;
  endfunction

  task automatic queue_cmd(input cmd_t cmd, input logic [7:0] ch, input logic [3:0] fg,
                           input logic [3:0] bg, input logic [10:0] addr);
    console_cmd_t c;
    c.cmd = cmd;
    c.ch = ch;
    c.fg = fg;
    c.bg = bg;
    c.addr = addr;
    command_backlog.push_back(c);
  endtask

  task automatic report(input string msg);
    error_count = error_count + 1;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic wait_drained;
    while (command_backlog.size() != 0 || start || pending_results.size() != 0 || busy)
      @(posedge clk);
  endtask

  task automatic set_defaults(input logic [3:0] fg, input logic [3:0] bg);
    while (busy) @(posedge clk);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_DEFAULT_FG;
    cfg_data <= fg;
    @(posedge clk);
    model_fg = fg;
    @(negedge clk);
    cfg_index <= CFG_DEFAULT_BG;
    cfg_data <= bg;
    @(posedge clk);
    model_bg = bg;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // driver: bursts of beats separated by random gaps
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || beat_taken) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (command_backlog.size() > 0) begin
        beat = command_backlog.pop_front();
        command <= beat.cmd;
        char_code <= beat.ch;
        char_fg <= beat.fg;
        char_bg <= beat.bg;
        read_address <= beat.addr;
        start <= 1'b1;
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk) begin
    beat_taken <= !rst && start && !busy;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (done) begin
        if (pending_results.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          want = pending_results.pop_front();
          if (cursor_location !== want.loc)
            report($sformatf("cursor_location %0d, expected %0d", cursor_location, want.loc));
          if (scrolled !== want.scr)
            report($sformatf("scrolled %0b, expected %0b", scrolled, want.scr));
          if (read_data !== want.rdata)
            report($sformatf("read_data %h, expected %h", read_data, want.rdata));
        end
      end
      if (start && !busy) begin
        pending_results.push_back(next_console_result({cmd_t'(command), char_code, char_fg,
                                                       char_bg, read_address}));
      end
      if ((start && !busy) || done || cfg_write) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog expired at %0t", $time);
          $display("FAIL text_console_char_writer");
          $finish;
        end
      end
    end
  end

  initial begin
    logic [3:0] pick_fg;
    logic [3:0] pick_bg;
    rst = 1'b1;
    start = 1'b0;
    command = CMD_WRITE_DEFAULT;
    char_code = 8'h00;
    char_fg = 4'h0;
    char_bg = 4'h0;
    read_address = 11'h000;
    cfg_write = 1'b0;
    cfg_index = CFG_DEFAULT_FG;
    cfg_data = 4'h0;
    beat_taken = 1'b0;
    gap_left = 0;
    burst_left = 0;
    error_count = 0;
    model_col = 0;
    model_row = 0;
    model_fg = 4'hF;
    model_bg = 4'h0;
    for (int i = 0; i < CELLS; i++) screen_model[i] = 16'h0000;

    // directed: reset defaults, field extremes, control bytes, reads, tab wrap
    queue_cmd(CMD_WRITE_DEFAULT, 8'h41, 4'h0, 4'h0, 11'h000);
    queue_cmd(CMD_CLEAR, 8'hFF, 4'hF, 4'hF, ADDR_TOP);
    queue_cmd(CMD_WRITE_DEFAULT, CH_BACKSPACE, 4'h0, 4'h0, 11'h000);
    queue_cmd(CMD_WRITE_DEFAULT, CH_SPACE, 4'h0, 4'h0, 11'h000);
    queue_cmd(CMD_WRITE_COLOR, 8'h7F, 4'h0, 4'hF, 11'h000);
    queue_cmd(CMD_WRITE_COLOR, CH_HIGH_START, 4'hF, 4'h0, 11'h000);
    queue_cmd(CMD_WRITE_DEFAULT, 8'hFF, 4'h0, 4'h0, 11'h000);
    queue_cmd(CMD_WRITE_DEFAULT, 8'h00, 4'h0, 4'h0, 11'h000);
    queue_cmd(CMD_WRITE_DEFAULT, CH_BACKSPACE, 4'h0, 4'h0, 11'h000);
    queue_cmd(CMD_WRITE_COLOR, CH_RETURN, 4'h0, 4'h0, 11'h000);
    queue_cmd(CMD_READ, 8'h00, 4'h0, 4'h0, 11'd0);
    queue_cmd(CMD_READ, 8'h00, 4'h0, 4'h0, 11'd1);
    queue_cmd(CMD_READ, 8'h00, 4'h0, 4'h0, 11'(CELLS - 1));
    queue_cmd(CMD_READ, 8'h00, 4'h0, 4'h0, ADDR_TOP);
    queue_cmd(CMD_WRITE_DEFAULT, CH_NEWLINE, 4'h0, 4'h0, 11'h000);
    // tabs run off the end of the line and wrap
    for (int i = 0; i < 10; i++) queue_cmd(CMD_WRITE_DEFAULT, CH_TAB, 4'h0, 4'h0, 11'h000);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    wait_drained();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: set_defaults(4'h0, 4'hF);
        1: set_defaults(4'hF, 4'hF);
        2: set_defaults(4'h0, 4'h0);
        3: begin
          pick_fg = 4'($urandom_range(1, 14));
          pick_bg = 4'($urandom_range(1, 14));
          set_defaults(pick_fg, pick_bg);
        end
        default: set_defaults(4'hF, 4'h0);
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) command_backlog.push_back(random_command(phase[0]));
      wait_drained();
    end

    repeat (END_PAUSE) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS text_console_char_writer");
    end else begin
      $display("FAIL text_console_char_writer");
    end
    $finish;
  end

endmodule
